/* hw/rtl/assert_macros.svh */
// Assertion macros for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every clock edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that an expression is never true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

/* hw/rtl/gvg_pkg.sv */
// Constants, exp table and result packing for the Gaussian value and gradient block.
package gvg_pkg;

    localparam int FRAC_BITS = 16;
    localparam int EXP_DEPTH = 256;
    localparam int EXP_DB    = $clog2(EXP_DEPTH);

    localparam int YW   = FRAC_BITS + 3;
    localparam int SQW  = 2 * YW;
    localparam int UW   = SQW - FRAC_BITS - 1;
    localparam int FW   = FRAC_BITS + 4;
    localparam int EW   = 31;
    localparam int PDW  = EW + FW;
    localparam int GW   = 17;
    localparam int VW   = 32;
    localparam int TW   = 35;
    localparam int MW   = 49;
    localparam int MAGW = 53;
    localparam int NSTG = 17;

    typedef enum logic [1:0] {
        CFG_MEAN      = 2'd0,
        CFG_INV_WIDTH = 2'd1,
        CFG_AMPLITUDE = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [31:0] val;
        logic        sat;
    } t_pack;

    typedef logic [EW-1:0] t_exp_tab [0:EXP_DEPTH];

    localparam logic [63:0] ONE30 = 64'd1 << 30;
    localparam logic [63:0] EXP_H = (64'd16 << 30) / EXP_DEPTH;

    localparam logic [63:0] EXP_T1  = (ONE30  * EXP_H) / (64'd1  << 30);
    localparam logic [63:0] EXP_T2  = (EXP_T1  * EXP_H) / (64'd2  << 30);
    localparam logic [63:0] EXP_T3  = (EXP_T2  * EXP_H) / (64'd3  << 30);
    localparam logic [63:0] EXP_T4  = (EXP_T3  * EXP_H) / (64'd4  << 30);
    localparam logic [63:0] EXP_T5  = (EXP_T4  * EXP_H) / (64'd5  << 30);
    localparam logic [63:0] EXP_T6  = (EXP_T5  * EXP_H) / (64'd6  << 30);
    localparam logic [63:0] EXP_T7  = (EXP_T6  * EXP_H) / (64'd7  << 30);
    localparam logic [63:0] EXP_T8  = (EXP_T7  * EXP_H) / (64'd8  << 30);
    localparam logic [63:0] EXP_T9  = (EXP_T8  * EXP_H) / (64'd9  << 30);
    localparam logic [63:0] EXP_T10 = (EXP_T9  * EXP_H) / (64'd10 << 30);
    localparam logic [63:0] EXP_T11 = (EXP_T10 * EXP_H) / (64'd11 << 30);
    localparam logic [63:0] EXP_T12 = (EXP_T11 * EXP_H) / (64'd12 << 30);
    localparam logic [63:0] EXP_T13 = (EXP_T12 * EXP_H) / (64'd13 << 30);
    localparam logic [63:0] EXP_T14 = (EXP_T13 * EXP_H) / (64'd14 << 30);
    localparam logic [63:0] EXP_T15 = (EXP_T14 * EXP_H) / (64'd15 << 30);

    // exp(-h) in Q0.30 from the Taylor series
    localparam logic [63:0] EXP_R = ONE30 + EXP_T2 + EXP_T4 + EXP_T6 + EXP_T8 + EXP_T10
                                  + EXP_T12 + EXP_T14
                                  - (EXP_T1 + EXP_T3 + EXP_T5 + EXP_T7 + EXP_T9 + EXP_T11
                                     + EXP_T13 + EXP_T15);

    function automatic t_exp_tab build_exp_tab();
        t_exp_tab    e;
        logic [63:0] acc;
        e[0] = EW'(ONE30);
        for (int k = 0; k < EXP_DEPTH; k++) begin
            acc      = 64'(e[k]) * EXP_R + (ONE30 >> 1);
            e[k + 1] = EW'(acc >> 30);
        end
        return e;
    endfunction

    localparam t_exp_tab EXP_TAB = build_exp_tab();

    // Apply sign to a magnitude and clamp to the signed 32-bit range.
    function automatic t_pack pack_signed(input logic neg, input logic [MAGW-1:0] mag);
        t_pack res;
        res.sat = 1'b0;
        if (neg) begin
            if (mag > MAGW'(33'h0_8000_0000)) begin
                res.val = 32'h8000_0000;
                res.sat = 1'b1;
            end else begin
                res.val = 32'd0 - mag[31:0];
            end
        end else begin
            if (mag > MAGW'(32'h7FFF_FFFF)) begin
                res.val = 32'h7FFF_FFFF;
                res.sat = 1'b1;
            end else begin
                res.val = mag[31:0];
            end
        end
        return res;
    endfunction

endpackage

/* hw/rtl/gaussian_value_and_gradient.sv */
// Gaussian value and gradient evaluator, 17-stage pipeline, top level.
//
// Takes one sample per clock: busy is always low and every start transfers a sample.
// Each result appears on the outputs for one cycle with o_strobe high, once its start
// transfer has passed every stage; results leave in the order the samples came in. The latency is
// set by the seven multiplications of the data path (x-mean by 1/sigma, y squared, the
// exp interpolation, amplitude by factor, value by y, and the two-part products for the
// mean and width gradients), each but the square with its rounding in a stage of its own. The receiver
// cannot stall the outputs. Write the mean, 1/sigma and amplitude registers only while
// no sample is in flight.
module gaussian_value_and_gradient
    import gvg_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic signed [31:0]  i_sample_x,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_idx,
    input  logic [31:0]         i_cfg_data,
    output logic                o_strobe,
    output logic signed [31:0]  o_model_value,
    output logic signed [31:0]  o_slope_x,
    output logic [GW-1:0]       o_grad_amplitude,
    output logic signed [31:0]  o_grad_mean,
    output logic signed [31:0]  o_grad_width,
    output logic                o_saturated
);

    logic [31:0]      r_mean;
    logic [31:0]      r_inv;
    logic [31:0]      r_amp;
    logic [NSTG-1:0]  r_vld;
    logic             w_accept;

    logic             r_aneg [0:15];
    logic             r_yneg0 [0:1];
    logic             r_yneg [2:15];
    logic [31:0]      r_am [0:6];
    logic [YW-1:0]    r_ym [2:13];
    logic             r_zg [2:5];
    logic [GW-1:0]    r_g [6:15];
    logic [VW-1:0]    r_vm [8:15];
    logic [MW-1:0]    r_mm [13:15];

    logic [32:0]      r_dm;
    logic [64:0]      r_p1;
    logic [SQW-1:0]   r_sq;
    logic [EW-1:0]    r_lo;
    logic [EW-1:0]    r_diff;
    logic [FW-1:0]    r_f;
    logic [EW-1:0]    r_lo2;
    logic [PDW-1:0]   r_pd;
    logic [48:0]      r_pa;
    logic [50:0]      r_pt;
    logic [TW-1:0]    r_t;
    logic [63:0]      r_pml;
    logic [34:0]      r_pmh;
    logic [67:0]      r_pms;
    logic [50:0]      r_pwl;
    logic [35:0]      r_pwh;
    logic [68:0]      r_pws;

    logic [31:0]      r_out_value;
    logic [31:0]      r_out_slope;
    logic [GW-1:0]    r_out_gamp;
    logic [31:0]      r_out_gmean;
    logic [31:0]      r_out_gwidth;
    logic             r_out_sat;

    logic [32:0]      n_d;
    logic [32:0]      n_dm;
    logic [31:0]      n_am;
    logic [65:0]      n_p1r;
    logic             n_big;
    logic [YW-1:0]    n_ym;
    logic [UW-1:0]    n_u;
    logic [FW-1:0]    n_u20;
    logic [EXP_DB-1:0] n_i;
    logic [EW-1:0]    n_lo;
    logic [EW-1:0]    n_hi;
    logic [31:0]      n_gsum;
    logic [EW-1:0]    n_g30;
    logic [GW-1:0]    n_g;
    logic [49:0]      n_vsum;
    logic [51:0]      n_tsum;
    logic [51:0]      n_mmf;
    logic [MW-1:0]    n_mm;
    logic             n_gneg;
    t_pack            n_pk_value;
    t_pack            n_pk_slope;
    t_pack            n_pk_gmean;
    t_pack            n_pk_gwidth;

    assign busy     = 1'b0;
    assign w_accept = start & ~busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mean <= 32'd65536;
            r_inv  <= 32'd65536;
            r_amp  <= 32'd65536;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MEAN:      r_mean <= i_cfg_data;
                CFG_INV_WIDTH: r_inv  <= i_cfg_data;
                CFG_AMPLITUDE: r_amp  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[NSTG-2:0], w_accept};
        end
    end

    always_comb begin
        n_d   = {i_sample_x[31], i_sample_x} - {r_mean[31], r_mean};
        n_dm  = n_d[32] ? (33'd0 - n_d) : n_d;
        n_am  = r_amp[31] ? (32'd0 - r_amp) : r_amp;

        n_p1r = {1'b0, r_p1} + (66'd1 << (FRAC_BITS - 1));
        n_big = |n_p1r[65:FRAC_BITS+YW];
        n_ym  = n_big ? '0 : n_p1r[FRAC_BITS+YW-1:FRAC_BITS];

        n_u   = r_sq[SQW-1:FRAC_BITS+1];
        n_u20 = n_u[FW-1:0];
        n_i   = n_u20[FW-1 -: EXP_DB];
        n_lo  = EXP_TAB[n_i];
        n_hi  = EXP_TAB[{1'b0, n_i} + (EXP_DB + 1)'(1)];

        n_g30 = r_lo2 - r_pd[PDW-1:FW];
        n_gsum = 32'(n_g30) + (32'd1 << 13);
        n_g   = r_zg[5] ? '0 : n_gsum[14 +: GW];

        n_vsum = 50'(r_pa) + (50'd1 << 15);
        n_tsum = 52'(r_pt) + (52'd1 << (FRAC_BITS - 1));

        n_mmf = r_pms[67:FRAC_BITS];
        n_mm  = (n_mmf >= (52'd1 << (MW - 1))) ? (MW'(1) << (MW - 1)) : n_mmf[MW-1:0];

        n_gneg      = r_aneg[15] ^ r_yneg[15];
        n_pk_value  = pack_signed(r_aneg[15], MAGW'(r_vm[15]));
        n_pk_slope  = pack_signed(~n_gneg, MAGW'(r_mm[15]));
        n_pk_gmean  = pack_signed(n_gneg, MAGW'(r_mm[15]));
        n_pk_gwidth = pack_signed(r_aneg[15], r_pws[68:FRAC_BITS]);
    end

    always_ff @(posedge i_clk) begin
        // stage 1: difference and magnitudes
        r_dm       <= n_dm;
        r_yneg0[0] <= n_d[32];
        r_aneg[0]  <= r_amp[31];
        r_am[0]    <= n_am;
        // stage 2: scale by 1/sigma
        r_p1       <= 65'(r_dm) * 65'(r_inv);
        r_yneg0[1] <= r_yneg0[0];
        // stage 3: round y, flag far tail
        r_ym[2]    <= n_ym;
        r_yneg[2]  <= r_yneg0[1] & (n_ym != '0);
        r_zg[2]    <= n_big;
        // stage 4: square
        r_sq       <= SQW'(r_ym[2]) * SQW'(r_ym[2]);
        r_zg[3]    <= r_zg[2];
        // stage 5: table lookup
        r_lo       <= n_lo;
        r_diff     <= (n_lo >= n_hi) ? (n_lo - n_hi) : '0;
        r_f        <= {n_u20[FW-1-EXP_DB:0], EXP_DB'(0)};
        r_zg[4]    <= r_zg[3] | n_u[UW-1];
        // stage 6: interpolation product
        r_pd       <= PDW'(r_diff) * PDW'(r_f);
        r_lo2      <= r_lo;
        r_zg[5]    <= r_zg[4];
        // stage 7: Gaussian factor
        r_g[6]     <= n_g;
        // stage 8: amplitude product
        r_pa       <= 49'(r_am[6]) * 49'(r_g[6]);
        // stage 9: value magnitude
        r_vm[8]    <= n_vsum[16 +: VW];
        // stage 10: value times y
        r_pt       <= 51'(r_vm[8]) * 51'(r_ym[8]);
        // stage 11: round
        r_t        <= n_tsum[FRAC_BITS +: TW];
        // stage 12: times 1/sigma in two parts
        r_pml      <= 64'(r_t[31:0]) * 64'(r_inv);
        r_pmh      <= 35'(r_t[TW-1:32]) * 35'(r_inv);
        // stage 13: combine parts
        r_pms      <= 68'(r_pml) + 68'({r_pmh, 32'd0}) + (68'd1 << (FRAC_BITS - 1));
        // stage 14: mean gradient magnitude, capped
        r_mm[13]   <= n_mm;
        // stage 15: times y in two parts
        r_pwl      <= 51'(r_mm[13][31:0]) * 51'(r_ym[13]);
        r_pwh      <= 36'(r_mm[13][MW-1:32]) * 36'(r_ym[13]);
        // stage 16: combine parts
        r_pws      <= 69'(r_pwl) + 69'({r_pwh, 32'd0}) + (69'd1 << (FRAC_BITS - 1));
        r_mm[15]   <= r_mm[14];
        // stage 17: sign, clamp, output
        r_out_value  <= n_pk_value.val;
        r_out_slope  <= n_pk_slope.val;
        r_out_gamp   <= r_g[15];
        r_out_gmean  <= n_pk_gmean.val;
        r_out_gwidth <= n_pk_gwidth.val;
        r_out_sat    <= n_pk_value.sat | n_pk_slope.sat | n_pk_gmean.sat | n_pk_gwidth.sat;

        r_mm[14] <= r_mm[13];
        for (int k = 1; k <= 15; k++) begin
            r_aneg[k] <= r_aneg[k-1];
        end
        for (int k = 3; k <= 15; k++) begin
            r_yneg[k] <= r_yneg[k-1];
        end
        for (int k = 1; k <= 6; k++) begin
            r_am[k] <= r_am[k-1];
        end
        for (int k = 3; k <= 13; k++) begin
            r_ym[k] <= r_ym[k-1];
        end
        for (int k = 7; k <= 15; k++) begin
            r_g[k] <= r_g[k-1];
        end
        for (int k = 9; k <= 15; k++) begin
            r_vm[k] <= r_vm[k-1];
        end
    end

    assign o_strobe         = r_vld[NSTG-1];
    assign o_model_value    = r_out_value;
    assign o_slope_x        = r_out_slope;
    assign o_grad_amplitude = r_out_gamp;
    assign o_grad_mean      = r_out_gmean;
    assign o_grad_width     = r_out_gwidth;
    assign o_saturated      = r_out_sat;

`include "assert_macros.svh"

    `ASSERT_PROP(a_strobe_after_transfer, i_clk, i_rst_n, o_strobe |-> $past(start && !busy, NSTG), "result without a sample transfer")
    `ASSERT_PROP(a_tail_all_zero, i_clk, i_rst_n, (o_strobe && o_grad_amplitude == '0) |-> (o_model_value == '0 && o_slope_x == '0 && o_grad_mean == '0 && o_grad_width == '0 && !o_saturated), "nonzero result with zero factor")
    `ASSERT_NEVER(a_factor_range, i_clk, i_rst_n, o_strobe && o_grad_amplitude > GW'(65536), "Gaussian factor above one")

endmodule
